// ===== rtl/mva2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mva2d_pkg: shared types and constants
// Op and status codes, geometric product term tables.
// ----------------------------------------------------------------------------
package mva2d_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_NEG   = 3'd2,
        OP_GPROD = 3'd3,
        OP_SCALE = 3'd4,
        OP_DIV   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // component order: scalar, e1, e2, e12
    typedef logic [1:0] t_idx;
    typedef t_idx t_idx_tab [4][4];
    typedef logic t_neg_tab [4][4];

    localparam t_idx_tab GP_A = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };
    localparam t_idx_tab GP_B = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };
    localparam t_neg_tab GP_N = '{
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1}
    };

endpackage

// ===== rtl/mva2d_if.sv =====
// ----------------------------------------------------------------------------
// mva2d_in_if / mva2d_out_if: request channels
// Valid/ready channels carrying operand and result multivectors.
// ----------------------------------------------------------------------------
interface mva2d_in_if #(
    parameter int WORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    op;
    logic signed [WORD_WIDTH-1:0]  a_scalar;
    logic signed [WORD_WIDTH-1:0]  a_x;
    logic signed [WORD_WIDTH-1:0]  a_y;
    logic signed [WORD_WIDTH-1:0]  a_bivector;
    logic signed [WORD_WIDTH-1:0]  b_scalar;
    logic signed [WORD_WIDTH-1:0]  b_x;
    logic signed [WORD_WIDTH-1:0]  b_y;
    logic signed [WORD_WIDTH-1:0]  b_bivector;
    logic signed [WORD_WIDTH-1:0]  factor;

    modport source (output valid, op, a_scalar, a_x, a_y, a_bivector,
                    b_scalar, b_x, b_y, b_bivector, factor, input ready);
    modport sink   (input valid, op, a_scalar, a_x, a_y, a_bivector,
                    b_scalar, b_x, b_y, b_bivector, factor, output ready);
endinterface

interface mva2d_out_if #(
    parameter int WORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [WORD_WIDTH-1:0]  r_scalar;
    logic signed [WORD_WIDTH-1:0]  r_x;
    logic signed [WORD_WIDTH-1:0]  r_y;
    logic signed [WORD_WIDTH-1:0]  r_bivector;
    logic [1:0]                    status;

    modport source (output valid, r_scalar, r_x, r_y, r_bivector, status,
                    input ready);
    modport sink   (input valid, r_scalar, r_x, r_y, r_bivector, status,
                    output ready);
endinterface

// ===== rtl/multivector_2d_alu.sv =====
// ----------------------------------------------------------------------------
// multivector_2d_alu: 2D multivector arithmetic unit
// Add, subtract, negate, geometric product, scale and divide on Q-format
// multivectors, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
//  channel  dir  content
//  i_in     in   op, a multivector, b multivector, factor
//  o_out    out  result multivector, status
//
//  One request per cycle while o_out is not stalled; pipeline depth is set by
//  the restoring divider, one quotient bit per stage.
//  Products take one stage, the four-term sum and rounding one, saturation one.
//  Reset clears valid bits only. A stall of o_out freezes the whole pipe.
module multivector_2d_alu #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mva2d_in_if.sink            i_in,
    mva2d_out_if.source         o_out
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 3;
    localparam int Q  = W + F;
    localparam int D  = Q + 2;

    localparam logic [Q-1:0] NEG_LIM = Q'(1) << (W - 1);
    localparam logic [Q-1:0] POS_LIM = NEG_LIM - Q'(1);
    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;
    logic [D-1:0] r_vld;

    assign en         = !r_vld[D-1] || o_out.ready;
    assign i_in.ready = en;

    // input unpack
    logic signed [W-1:0] a_in [4];
    logic signed [W-1:0] b_in [4];
    mva2d_pkg::t_op      op_in;

    assign a_in[0] = i_in.a_scalar;
    assign a_in[1] = i_in.a_x;
    assign a_in[2] = i_in.a_y;
    assign a_in[3] = i_in.a_bivector;
    assign b_in[0] = i_in.b_scalar;
    assign b_in[1] = i_in.b_x;
    assign b_in[2] = i_in.b_y;
    assign b_in[3] = i_in.b_bivector;
    assign op_in   = mva2d_pkg::t_op'(i_in.op);

    // valid and op lines
    mva2d_pkg::t_op r_op [Q+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[D-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op[0] <= op_in;
            for (int s = 1; s <= Q; s++) begin
                r_op[s] <= r_op[s-1];
            end
        end
    end

    // stage 1: operand select, products, linear ops
    logic signed [W-1:0]  x_sel [4][4];
    logic signed [W-1:0]  y_sel [4][4];
    logic                 g_sel [4][4];
    logic signed [W:0]    n_lin [4];
    logic signed [PW-1:0] r_prod [4][4];
    logic                 r_pneg [4][4];
    logic signed [W:0]    r_lin [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                x_sel[c][k] = '0;
                y_sel[c][k] = '0;
                g_sel[c][k] = 1'b0;
                case (op_in)
                    mva2d_pkg::OP_GPROD: begin
                        x_sel[c][k] = a_in[mva2d_pkg::GP_A[c][k]];
                        y_sel[c][k] = b_in[mva2d_pkg::GP_B[c][k]];
                        g_sel[c][k] = mva2d_pkg::GP_N[c][k];
                    end
                    mva2d_pkg::OP_SCALE: begin
                        if (k == 0) begin
                            x_sel[c][k] = a_in[c];
                            y_sel[c][k] = i_in.factor;
                        end
                    end
                    default: ;
                endcase
            end
            case (op_in)
                mva2d_pkg::OP_ADD: n_lin[c] = (W+1)'(a_in[c]) + (W+1)'(b_in[c]);
                mva2d_pkg::OP_SUB: n_lin[c] = (W+1)'(a_in[c]) - (W+1)'(b_in[c]);
                mva2d_pkg::OP_NEG: n_lin[c] = -(W+1)'(a_in[c]);
                default:           n_lin[c] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[c][k] <= x_sel[c][k] * y_sel[c][k];
                    r_pneg[c][k] <= g_sel[c][k];
                end
                r_lin[c] <= n_lin[c];
            end
        end
    end

    // stage 2: exact sum, round half up
    logic signed [SW-1:0] n_sum [4];
    logic signed [SW-1:0] r_sum [4];
    logic                 mul_op1;

    assign mul_op1 = (r_op[0] == mva2d_pkg::OP_GPROD) || (r_op[0] == mva2d_pkg::OP_SCALE);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = '0;
            for (int k = 0; k < 4; k++) begin
                if (r_pneg[c][k]) begin
                    n_sum[c] = n_sum[c] - SW'(r_prod[c][k]);
                end else begin
                    n_sum[c] = n_sum[c] + SW'(r_prod[c][k]);
                end
            end
            if (mul_op1) begin
                n_sum[c] = (n_sum[c] + (SW'(1) <<< (F - 1))) >>> F;
            end else begin
                n_sum[c] = SW'(r_lin[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= n_sum;
        end
    end

    // stage 3: saturate, then delay to divider depth
    logic signed [W-1:0] n_ares [4];
    logic                n_asat [4];
    logic signed [W-1:0] r_ares [Q-1][4];
    logic                r_asat [Q-1];
    logic [SW-W:0]       hi_bits [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            hi_bits[c] = r_sum[c][SW-1:W-1];
            n_asat[c]  = !((&hi_bits[c]) || !(|hi_bits[c]));
            if (!n_asat[c]) begin
                n_ares[c] = r_sum[c][W-1:0];
            end else if (r_sum[c][SW-1]) begin
                n_ares[c] = W_MIN;
            end else begin
                n_ares[c] = W_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ares[0] <= n_ares;
            r_asat[0] <= n_asat[0] | n_asat[1] | n_asat[2] | n_asat[3];
            for (int s = 1; s < Q - 1; s++) begin
                r_ares[s] <= r_ares[s-1];
                r_asat[s] <= r_asat[s-1];
            end
        end
    end

    // divider: stage 1 magnitudes, then one quotient bit per stage
    logic [W-1:0] r_drem [Q+1][4];
    logic [Q-1:0] r_dnum [Q+1][4];
    logic [Q-1:0] r_dq   [Q+1][4];
    logic         r_dsg  [Q+1][4];
    logic [W-1:0] r_ddm  [Q+1];
    logic         r_ddz  [Q+1];

    logic [W-1:0] n_drem [Q][4];
    logic [W:0]   trial  [Q][4];
    logic         ge     [Q][4];

    always_comb begin
        for (int s = 0; s < Q; s++) begin
            for (int c = 0; c < 4; c++) begin
                trial[s][c] = {r_drem[s][c], r_dnum[s][c][Q-1]};
                ge[s][c]    = trial[s][c] >= {1'b0, r_ddm[s]};
                if (ge[s][c]) begin
                    n_drem[s][c] = W'(trial[s][c] - {1'b0, r_ddm[s]});
                end else begin
                    n_drem[s][c] = trial[s][c][W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_drem[0][c] <= '0;
                r_dnum[0][c] <= {(a_in[c][W-1] ? W'(-a_in[c]) : W'(a_in[c])), F'(0)};
                r_dq[0][c]   <= '0;
                r_dsg[0][c]  <= a_in[c][W-1] ^ i_in.factor[W-1];
            end
            r_ddm[0] <= i_in.factor[W-1] ? W'(-i_in.factor) : W'(i_in.factor);
            r_ddz[0] <= (i_in.factor == '0);
            for (int s = 0; s < Q; s++) begin
                for (int c = 0; c < 4; c++) begin
                    r_drem[s+1][c] <= n_drem[s][c];
                    r_dnum[s+1][c] <= {r_dnum[s][c][Q-2:0], 1'b0};
                    r_dq[s+1][c]   <= {r_dq[s][c][Q-2:0], ge[s][c]};
                    r_dsg[s+1][c]  <= r_dsg[s][c];
                end
                r_ddm[s+1] <= r_ddm[s];
                r_ddz[s+1] <= r_ddz[s];
            end
        end
    end

    // output stage
    logic signed [W-1:0] n_dres [4];
    logic                n_dsat [4];
    logic signed [W-1:0] n_ores [4];
    mva2d_pkg::t_status  n_ost;
    logic signed [W-1:0] r_ores [4];
    mva2d_pkg::t_status  r_ost;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_dsat[c] = 1'b0;
            if (r_dsg[Q][c]) begin
                if (r_dq[Q][c] > NEG_LIM) begin
                    n_dres[c] = W_MIN;
                    n_dsat[c] = 1'b1;
                end else begin
                    n_dres[c] = -W'(r_dq[Q][c]);
                end
            end else begin
                if (r_dq[Q][c] > POS_LIM) begin
                    n_dres[c] = W_MAX;
                    n_dsat[c] = 1'b1;
                end else begin
                    n_dres[c] = W'(r_dq[Q][c]);
                end
            end
        end
        if (r_op[Q] == mva2d_pkg::OP_DIV) begin
            if (r_ddz[Q]) begin
                for (int c = 0; c < 4; c++) begin
                    n_ores[c] = '0;
                end
                n_ost = mva2d_pkg::ST_DIVZ;
            end else begin
                n_ores = n_dres;
                n_ost  = (n_dsat[0] | n_dsat[1] | n_dsat[2] | n_dsat[3]) ?
                         mva2d_pkg::ST_SAT : mva2d_pkg::ST_OK;
            end
        end else begin
            n_ores = r_ares[Q-2];
            n_ost  = r_asat[Q-2] ? mva2d_pkg::ST_SAT : mva2d_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ores <= n_ores;
            r_ost  <= n_ost;
        end
    end

    assign o_out.valid      = r_vld[D-1];
    assign o_out.r_scalar   = r_ores[0];
    assign o_out.r_x        = r_ores[1];
    assign o_out.r_y        = r_ores[2];
    assign o_out.r_bivector = r_ores[3];
    assign o_out.status     = r_ost;

    // checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status != 2'd3))
        else $error("illegal status code");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == mva2d_pkg::ST_DIVZ) |->
        (o_out.r_scalar == '0 && o_out.r_x == '0 && o_out.r_y == '0 &&
         o_out.r_bivector == '0))
        else $error("divide by zero with nonzero result");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == mva2d_pkg::ST_SAT) |->
        (o_out.r_scalar == W_MAX || o_out.r_scalar == W_MIN ||
         o_out.r_x == W_MAX || o_out.r_x == W_MIN ||
         o_out.r_y == W_MAX || o_out.r_y == W_MIN ||
         o_out.r_bivector == W_MAX || o_out.r_bivector == W_MIN))
        else $error("saturation flagged without a clamped component");

endmodule

// ===== bench/multivector_2d_alu_tb.sv =====
// ----------------------------------------------------------------------------
// multivector_2d_alu_tb: self-checking bench for the 2D multivector ALU
// Directed corner requests, then random requests of every op. Expected
// results come from a behavioral model kept in a queue and are compared
// with each accepted result, with random gaps on both channels.
// ----------------------------------------------------------------------------
module multivector_2d_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int WW = 32;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]        op;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] f;
    } t_req;

    typedef struct {
        logic signed [31:0] r [4];
        logic [1:0]         st;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mva2d_in_if  #(.WORD_WIDTH(WW)) in_ch ();
    mva2d_out_if #(.WORD_WIDTH(WW)) out_ch ();

    multivector_2d_alu #(.FRAC_BITS(FB), .WORD_WIDTH(WW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_req pending_q [$];
    t_res result_q [$];
    int   errors = 0;
    int   wdog = 0;
    bit   stim_done = 0;
    int   src_gap = 0;
    int   snk_gap = 0;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [127:0] v, ref bit sat);
        if (v > 128'sd2147483647) begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round to nearest, ties toward +inf: floor(x/2^FB + 1/2)
    function automatic logic signed [127:0] round_q(logic signed [127:0] x);
        return (x + (128'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic t_res mv_compute(t_req q);
        t_res res;
        logic signed [127:0] w [4];
        logic signed [127:0] s, num, den, quo;
        bit sat;
        sat = 0;
        res.st = mva2d_pkg::ST_OK;
        for (int i = 0; i < 4; i++) w[i] = 0;
        case (q.op)
            mva2d_pkg::OP_ADD:
                for (int i = 0; i < 4; i++) w[i] = 128'(q.a[i]) + 128'(q.b[i]);
            mva2d_pkg::OP_SUB:
                for (int i = 0; i < 4; i++) w[i] = 128'(q.a[i]) - 128'(q.b[i]);
            mva2d_pkg::OP_NEG:
                for (int i = 0; i < 4; i++) w[i] = -128'(q.a[i]);
            mva2d_pkg::OP_GPROD: begin
                w[0] = round_q(128'(q.a[0])*q.b[0] + 128'(q.a[1])*q.b[1]
                             + 128'(q.a[2])*q.b[2] - 128'(q.a[3])*q.b[3]);
                w[1] = round_q(128'(q.a[0])*q.b[1] + 128'(q.a[1])*q.b[0]
                             - 128'(q.a[2])*q.b[3] + 128'(q.a[3])*q.b[2]);
                w[2] = round_q(128'(q.a[0])*q.b[2] + 128'(q.a[2])*q.b[0]
                             + 128'(q.a[1])*q.b[3] - 128'(q.a[3])*q.b[1]);
                w[3] = round_q(128'(q.a[0])*q.b[3] + 128'(q.a[3])*q.b[0]
                             + 128'(q.a[1])*q.b[2] - 128'(q.a[2])*q.b[1]);
            end
            mva2d_pkg::OP_SCALE:
                for (int i = 0; i < 4; i++) w[i] = round_q(128'(q.a[i]) * q.f);
            mva2d_pkg::OP_DIV: begin
                if (q.f == 0) res.st = mva2d_pkg::ST_DIVZ;
                else begin
                    for (int i = 0; i < 4; i++) begin
                        num = 128'(q.a[i]) <<< FB;
                        den = 128'(q.f);
                        s = (num < 0) ? -num : num;
                        quo = s / ((den < 0) ? -den : den);
                        w[i] = ((num < 0) != (den < 0)) ? -quo : quo;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) res.r[i] = clamp(w[i], sat);
        if (sat && res.st == mva2d_pkg::ST_OK) res.st = mva2d_pkg::ST_SAT;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
            4: return $signed($urandom_range(0, 32'h1ff)) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.op = 3'($urandom_range(0, 7));
        if (q.op > mva2d_pkg::OP_DIV && $urandom_range(0, 3) != 0)
            q.op = 3'($urandom_range(0, mva2d_pkg::OP_DIV));
        for (int i = 0; i < 4; i++) begin
            q.a[i] = rand_word();
            q.b[i] = rand_word();
        end
        q.f = ($urandom_range(0, 9) == 0) ? 0 : rand_word();
        return q;
    endfunction

    task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s[%0d]: got %h want %h", what, idx, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready) result_q.push_back(mv_compute(pending_q.pop_front()));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                in_ch.valid      <= 1'b1;
                in_ch.op         <= pending_q[0].op;
                in_ch.a_scalar   <= pending_q[0].a[0];
                in_ch.a_x        <= pending_q[0].a[1];
                in_ch.a_y        <= pending_q[0].a[2];
                in_ch.a_bivector <= pending_q[0].a[3];
                in_ch.b_scalar   <= pending_q[0].b[0];
                in_ch.b_x        <= pending_q[0].b[1];
                in_ch.b_y        <= pending_q[0].b[2];
                in_ch.b_bivector <= pending_q[0].b[3];
                in_ch.factor     <= pending_q[0].f;
                src_gap <= gap_len();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        logic signed [31:0] got [4];
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.r_scalar, out_ch.r_x, out_ch.r_y, out_ch.r_bivector};
                if (result_q.size() == 0) begin
                    report("unexpected", 0, 0, 0);
                end else begin
                    e = result_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== e.r[i]) report("component", i, got[i], e.r[i]);
                    if (out_ch.status !== e.st)
                        report("status", 0, 32'(out_ch.status), 32'(e.st));
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) snk_gap <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_req q;
        logic signed [31:0] ext [4];
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        {in_ch.a_scalar, in_ch.a_x, in_ch.a_y, in_ch.a_bivector} = '0;
        {in_ch.b_scalar, in_ch.b_x, in_ch.b_y, in_ch.b_bivector} = '0;
        in_ch.factor = '0;
        out_ch.ready = 1'b0;
        ext = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000};
        for (int o = 0; o < 8; o++) begin
            for (int k = 0; k < 3; k++) begin
                q.op = 3'(o);
                for (int i = 0; i < 4; i++) begin
                    q.a[i] = ext[(i + k) % 4];
                    q.b[i] = ext[(i + 2 * k + 1) % 4];
                end
                q.f = (k == 0) ? 0 : ext[k];
                pending_q.push_back(q);
            end
        end
        q.op = mva2d_pkg::OP_SCALE;
        q.a = '{32'sh00008000, -32'sh00008000, 32'sh00000001, -32'sh00000001};
        q.b = '{0, 0, 0, 0};
        q.f = 32'sh00000001;
        pending_q.push_back(q);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < 1750; n++) begin
            while (pending_q.size() > 8) @(posedge i_clk);
            pending_q.push_back(rand_req());
        end
        while (pending_q.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (result_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
